FILE: src/pwli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwli_pkg;

  // Width of every time and position word (signed Q16.16).
  localparam int DATA_W = 32;
  // Fraction bits of the blend weight (unsigned Q0.16).
  localparam int FRAC_W = 16;
  // Width of the knot count register and its value after reset.
  localparam int KNOT_COUNT_W = 5;
  localparam logic [KNOT_COUNT_W-1:0] KNOT_COUNT_RESET = 5'd2;
  // Default size of the knot table.
  localparam int MAX_KNOTS_DEF = 16;
  // Widths of the result's segment and clamp fields.
  localparam int SEG_W = 4;
  localparam int STATUS_W = 2;

  // Clamp status codes reported with every result.
  localparam logic [STATUS_W-1:0] CLAMP_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] CLAMP_FIRST = 2'd1;
  localparam logic [STATUS_W-1:0] CLAMP_LAST  = 2'd2;

  // Evaluation sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_PREAD0,
    S_PREAD1,
    S_PREAD2,
    S_DIVIDE,
    S_MUL,
    S_ADD
  } state_t;

endpackage

`default_nettype wire

FILE: src/pwli_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module pwli_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pwli_pkg::DATA_W-1:0]   num,
  input  logic [pwli_pkg::DATA_W-1:0]   den,
  output logic                          done,
  output logic [pwli_pkg::FRAC_W-1:0]   quotient
);

  import pwli_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] divisor;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   rem_diff;
  logic              fits;

  // One restoring step: shift the partial remainder and try the divisor.
  // The numerator is always below the divisor, so the quotient is pure fraction.
  assign rem_shift = {rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign fits      = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && (step == STEP_W'(FRAC_W - 1))) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num;
      divisor  <= den;
      step     <= '0;
      quotient <= '0;
    end else if (running) begin
      rem      <= fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      quotient <= {quotient[FRAC_W-2:0], fits};
      step     <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: src/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Piecewise linear interpolator over a table of MAX_KNOTS knots, each a time
// and an (x, y, z) position in signed Q16.16.
// Requests are taken on the command channel: a request is accepted at a rising
// edge where start is high and busy is low. With mode low the request loads one
// knot into slot knot_index in that same edge and gives no result; busy stays
// low, so loads may follow one another in every cycle. With mode high the
// request evaluates the polyline at query_time and busy stays high until the
// result has been produced.
// The result appears on pos_x, pos_y, pos_z, segment_index and clamp_status for
// exactly one cycle, marked by done; the receiver cannot hold it off, and the
// next request may already be accepted in that same cycle.
// An evaluation first tests the query against the first and the last knot; a
// query clamped to either returns that knot's position. Any other query runs a
// linear segment search over the table, then the 16-step restoring divider for
// the blend weight, then the single shared multiplier, used once per coordinate.
// The knot_count register is written over its own valid/ready channel while
// the block is idle. Reset sets knot_count to 2 and returns the sequencer to
// idle; the knot tables are not cleared and must be loaded before use.

module piecewise_linear_interpolator #(
  parameter int MAX_KNOTS = pwli_pkg::MAX_KNOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Command channel.
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic [3:0]                           knot_index,
  input  logic signed [pwli_pkg::DATA_W-1:0]   knot_time,
  input  logic signed [pwli_pkg::DATA_W-1:0]   knot_x,
  input  logic signed [pwli_pkg::DATA_W-1:0]   knot_y,
  input  logic signed [pwli_pkg::DATA_W-1:0]   knot_z,
  input  logic signed [pwli_pkg::DATA_W-1:0]   query_time,
  // Configuration channel for knot_count.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pwli_pkg::KNOT_COUNT_W-1:0]    cfg_data,
  // Result strobe and fields.
  output logic                                 done,
  output logic signed [pwli_pkg::DATA_W-1:0]   pos_x,
  output logic signed [pwli_pkg::DATA_W-1:0]   pos_y,
  output logic signed [pwli_pkg::DATA_W-1:0]   pos_z,
  output logic [pwli_pkg::SEG_W-1:0]           segment_index,
  output logic [pwli_pkg::STATUS_W-1:0]        clamp_status
);

  import pwli_pkg::*;

  localparam int IW    = $clog2(MAX_KNOTS);
  localparam int POS_W = 3 * DATA_W;
  localparam int PROD_W = DATA_W + 1 + FRAC_W + 1;

  state_t state, state_next;

  logic [KNOT_COUNT_W-1:0] knot_count;

  // Knot tables: one write port for loads, one registered read port each.
  logic signed [DATA_W-1:0] time_mem [MAX_KNOTS];
  logic [POS_W-1:0]         pos_mem  [MAX_KNOTS];
  logic signed [DATA_W-1:0] time_rdata;
  logic [POS_W-1:0]         pos_rdata;
  logic [IW-1:0]            time_raddr;
  logic [IW-1:0]            pos_raddr;
  logic                     load_en;

  // Evaluation working registers.
  logic signed [DATA_W-1:0] q;
  logic [IW-1:0]            last_idx;
  logic [IW-1:0]            last_idx_next;
  logic [IW-1:0]            idx;
  logic [IW-1:0]            seg;
  logic [STATUS_W-1:0]      clamp;
  logic signed [DATA_W-1:0] t_lo;
  logic signed [DATA_W-1:0] t_hi;
  logic signed [DATA_W-1:0] p0 [3];
  logic signed [DATA_W-1:0] p1 [3];
  logic [1:0]               coord;
  logic [FRAC_W-1:0]        u;
  logic signed [PROD_W-1:0] prod;

  logic                     hit;
  logic                     div_start;
  logic                     div_done;
  logic [FRAC_W-1:0]        div_quo;
  logic [DATA_W-1:0]        div_num;
  logic [DATA_W-1:0]        div_den;
  logic signed [DATA_W:0]   diff;
  logic signed [PROD_W-1:0] sum;
  logic signed [PROD_W-1:0] sum_adj;
  logic signed [DATA_W-1:0] blend;
  logic                     done_next;

  assign cfg_ready = (state == S_IDLE);
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= KNOT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      knot_count <= cfg_data;
    end
  end

  // The active count is held to the range 2..MAX_KNOTS; only its last index is kept.
  always_comb begin
    if (knot_count < KNOT_COUNT_W'(2)) begin
      last_idx_next = IW'(1);
    end else if (32'(knot_count) > MAX_KNOTS) begin
      last_idx_next = IW'(MAX_KNOTS - 1);
    end else begin
      last_idx_next = IW'(knot_count - 1'b1);
    end
  end

  // Loads to a slot beyond the table are dropped.
  assign load_en = (state == S_IDLE) && start && !mode && (32'(knot_index) < MAX_KNOTS);

  always_ff @(posedge clk) begin
    if (load_en) begin
      time_mem[IW'(knot_index)] <= knot_time;
      pos_mem[IW'(knot_index)]  <= {knot_z, knot_y, knot_x};
    end
    time_rdata <= time_mem[time_raddr];
    pos_rdata  <= pos_mem[pos_raddr];
  end

  // The search stops at the first knot whose time exceeds the query. The query
  // is already known to lie below the last active time, so the last segment is
  // taken if nothing earlier matched.
  assign hit = (q < time_rdata) || (idx == IW'(last_idx - 1'b1));

  assign div_num = DATA_W'(q - t_lo);
  assign div_den = DATA_W'(t_hi - t_lo);

  pwli_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Blend of one coordinate: (p0 << 16) + u * (p1 - p0), divided by 65536 with
  // truncation toward zero.
  assign diff    = {p1[coord][DATA_W-1], p1[coord]} - {p0[coord][DATA_W-1], p0[coord]};
  assign sum     = {{2{p0[coord][DATA_W-1]}}, p0[coord], {FRAC_W{1'b0}}} + prod;
  assign sum_adj = sum + {{(PROD_W - FRAC_W){1'b0}}, {FRAC_W{sum[PROD_W-1]}}};
  assign blend   = sum_adj[FRAC_W+DATA_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    done_next  = 1'b0;
    time_raddr = '0;
    pos_raddr  = seg;
    unique case (state)
      S_IDLE: begin
        time_raddr = '0;
        if (start && mode) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        time_raddr = last_idx;
        state_next = (q <= time_rdata) ? S_PREAD0 : S_LAST;
      end
      S_LAST: begin
        time_raddr = IW'(1);
        state_next = (q >= time_rdata) ? S_PREAD0 : S_SEARCH;
      end
      S_SEARCH: begin
        time_raddr = IW'(idx + 2'd2);
        if (hit) begin
          state_next = S_PREAD0;
        end
      end
      S_PREAD0: begin
        pos_raddr  = seg;
        state_next = S_PREAD1;
      end
      S_PREAD1: begin
        pos_raddr = IW'(seg + 1'b1);
        if (clamp != CLAMP_NONE) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_PREAD2;
        end
      end
      S_PREAD2: begin
        div_start  = 1'b1;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        if (coord == 2'd2) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_MUL;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start && mode) begin
          q        <= query_time;
          last_idx <= last_idx_next;
        end
      end
      S_FIRST: begin
        t_lo <= time_rdata;
        if (q <= time_rdata) begin
          seg   <= '0;
          clamp <= CLAMP_FIRST;
        end
      end
      S_LAST: begin
        idx <= '0;
        if (q >= time_rdata) begin
          seg   <= last_idx;
          clamp <= CLAMP_LAST;
        end else begin
          clamp <= CLAMP_NONE;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          t_hi <= time_rdata;
          seg  <= idx;
        end else begin
          t_lo <= time_rdata;
          idx  <= idx + 1'b1;
        end
      end
      S_PREAD1: begin
        p0[0] <= pos_rdata[DATA_W-1:0];
        p0[1] <= pos_rdata[2*DATA_W-1:DATA_W];
        p0[2] <= pos_rdata[3*DATA_W-1:2*DATA_W];
        if (clamp != CLAMP_NONE) begin
          pos_x         <= pos_rdata[DATA_W-1:0];
          pos_y         <= pos_rdata[2*DATA_W-1:DATA_W];
          pos_z         <= pos_rdata[3*DATA_W-1:2*DATA_W];
          segment_index <= SEG_W'(seg);
          clamp_status  <= clamp;
        end
      end
      S_PREAD2: begin
        p1[0] <= pos_rdata[DATA_W-1:0];
        p1[1] <= pos_rdata[2*DATA_W-1:DATA_W];
        p1[2] <= pos_rdata[3*DATA_W-1:2*DATA_W];
        coord <= '0;
      end
      S_DIVIDE: begin
        u <= div_quo;
      end
      S_MUL: begin
        prod <= diff * $signed({1'b0, u});
      end
      S_ADD: begin
        coord <= coord + 1'b1;
        case (coord)
          2'd0:    pos_x <= blend;
          2'd1:    pos_y <= blend;
          default: begin
            pos_z         <= blend;
            segment_index <= SEG_W'(seg);
            clamp_status  <= CLAMP_NONE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
